// ===== design/apjq_pkg.sv =====
// ---------------------------------------------------------------------------
// apjq_pkg
// Shared types and codes for the aging priority job queue.
// ---------------------------------------------------------------------------
package apjq_pkg;

   localparam logic [1:0] CMD_PUT = 2'd0;
   localparam logic [1:0] CMD_GET = 2'd1;
   localparam logic [1:0] CMD_DEL = 2'd2;

   localparam logic [0:0] REG_MAX_SIZE = 1'd0;
   localparam logic [0:0] REG_BUMP     = 1'd1;

   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned SIZE_BITS     = 5;

   typedef struct packed {
      logic load;       // latch request word, reset scan index
      logic div_start;  // begin aged priority division for current entry
      logic step;       // advance scan index
      logic do_insert;  // insert at scan index
      logic do_remove;  // remove at scan index
      logic finish;     // drive response word
      logic fail;       // response status is refusal
      logic pop;        // response carries head entry
   } ctrl_type;

   typedef struct packed {
      logic scan_end;   // scan index reached entry count
      logic full;
      logic empty;
      logic id_hit;     // entry at scan index matches id
      logic div_done;
      logic prio_gt;    // new priority beats aged priority at scan index
      logic [1:0] cmd;
   } stat_type;

endpackage

// ===== design/aging_priority_job_queue.sv =====
// ---------------------------------------------------------------------------
// aging_priority_job_queue
// Get, refused put and unused code respond from the dispatch state; delete
// scans until the id matches or the entry count is reached. Put runs one
// aged compare (33-step serial divider) per entry, inserting on the winning
// compare, or at the tail from the dispatch state. Next word once busy falls.
// Reset clears the entry count and CSR registers; no clearing pass. rsp_valid
// pulses one cycle and cannot be stalled.
// ---------------------------------------------------------------------------
module aging_priority_job_queue #(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned ID_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_job_id,
   input  logic [15:0] req_priority_req,
   input  logic [31:0] req_enqueue_time,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [15:0] rsp_out_job_id,
   output logic [15:0] rsp_out_priority,
   output logic [4:0]  rsp_queue_size,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   apjq_pkg::ctrl_type ctrl;
   apjq_pkg::stat_type stat;

   apjq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   apjq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_command      (req_command),
      .req_job_id       (req_job_id),
      .req_priority_req (req_priority_req),
      .req_enqueue_time (req_enqueue_time),
      .req_now          (req_now),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_job_id   (rsp_out_job_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_queue_size   (rsp_queue_size)
   );

endmodule

// ===== design/apjq_divider.sv =====
// ---------------------------------------------------------------------------
// apjq_divider
// Radix-2 restoring divider, signed 33-bit dividend by unsigned 32-bit
// divisor, quotient truncated toward zero.
// ---------------------------------------------------------------------------
module apjq_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [33:0] quotient
);

   logic [32:0] rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;
   logic [32:0] shifted;

   assign shifted = {rem_ff[31:0], quo_ff[32]};
   assign trial   = {1'b0, shifted} - {2'b00, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         neg_in  = dividend[32];
         quo_in  = dividend[32] ? (33'd0 - dividend) : dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[33]) begin
            rem_in = shifted;
            quo_in = {quo_ff[31:0], 1'b0};
         end else begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[31:0], 1'b1};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (34'd0 - {1'b0, quo_ff}) : {1'b0, quo_ff};

endmodule

// ===== design/apjq_datapath.sv =====
// ---------------------------------------------------------------------------
// apjq_datapath
// Shift-array job storage, request latch, aged compare and response word.
// ---------------------------------------------------------------------------
module apjq_datapath #(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned ID_BITS     = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  apjq_pkg::ctrl_type ctrl,
   output apjq_pkg::stat_type stat,
   input  logic [1:0]         req_command,
   input  logic [15:0]        req_job_id,
   input  logic [15:0]        req_priority_req,
   input  logic [31:0]        req_enqueue_time,
   input  logic [31:0]        req_now,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_valid,
   output logic               rsp_status,
   output logic [15:0]        rsp_out_job_id,
   output logic [15:0]        rsp_out_priority,
   output logic [4:0]         rsp_queue_size
);

   localparam int unsigned IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [ID_BITS-1:0] id_ff [QUEUE_DEPTH];
   logic [15:0]        pri_ff [QUEUE_DEPTH];
   logic [31:0]        tim_ff [QUEUE_DEPTH];
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS:0]   pos_ff, pos_in;
   logic [1:0]         cmd_ff;
   logic [ID_BITS-1:0] rid_ff;
   logic [15:0]        rpri_ff;
   logic [31:0]        rtim_ff;
   logic [31:0]        rnow_ff;
   logic [4:0]         max_ff;
   logic [31:0]        bump_ff;
   logic               valid_ff;
   logic               status_ff;
   logic [15:0]        oid_ff, opri_ff;
   logic [4:0]         osize_ff;
   logic [IDX_BITS-1:0] pidx;
   logic [32:0]        age;
   logic [33:0]        quo;
   logic               div_done;
   logic [34:0]        aged;
   logic [CNT_BITS:0]  max_ext;

   assign pidx = pos_ff[IDX_BITS-1:0];
   assign age  = {1'b0, rnow_ff} - {1'b0, tim_ff[pidx]};

   apjq_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (age),
      .divisor  (bump_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign aged = {19'd0, pri_ff[pidx]}
               + ((bump_ff != 32'd0) ? {quo[33], quo} : 35'd0);
   assign max_ext = ({27'd0, max_ff} > 32'(QUEUE_DEPTH))
                    ? (CNT_BITS + 1)'(QUEUE_DEPTH) : (CNT_BITS + 1)'(max_ff);

   always_comb begin
      stat.cmd      = cmd_ff;
      stat.scan_end = (pos_ff >= {1'b0, count_ff});
      stat.empty    = (count_ff == '0);
      stat.full     = (count_ff == CNT_BITS'(QUEUE_DEPTH))
                    || (max_ff != 5'd0 && {1'b0, count_ff} >= max_ext);
      stat.id_hit   = (id_ff[pidx] == rid_ff);
      stat.div_done = div_done;
      stat.prio_gt  = $signed({19'd0, rpri_ff}) > $signed(aged);
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      if (ctrl.load) pos_in = '0;
      else if (ctrl.step) pos_in = pos_ff + (CNT_BITS + 1)'(1);
      if (ctrl.do_insert) count_in = count_ff + CNT_BITS'(1);
      if (ctrl.do_remove) count_in = count_ff - CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= '0;
         bump_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= ctrl.finish;
         if (csr_write) begin
            case (csr_index)
               apjq_pkg::REG_MAX_SIZE: max_ff  <= csr_data[4:0];
               apjq_pkg::REG_BUMP:     bump_ff <= csr_data;
               default: ;
            endcase
         end
      end
      pos_ff <= pos_in;
      if (ctrl.load) begin
         cmd_ff  <= req_command;
         rid_ff  <= ID_BITS'(req_job_id);
         rpri_ff <= req_priority_req;
         rtim_ff <= req_enqueue_time;
         rnow_ff <= req_now;
      end
      if (ctrl.do_insert) begin
         for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (IDX_BITS'(i) > pidx) begin
               id_ff[i]  <= id_ff[i-1];
               pri_ff[i] <= pri_ff[i-1];
               tim_ff[i] <= tim_ff[i-1];
            end
         end
         id_ff[pidx]  <= rid_ff;
         pri_ff[pidx] <= rpri_ff;
         tim_ff[pidx] <= rtim_ff;
      end else if (ctrl.do_remove) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (IDX_BITS'(i) >= pidx) begin
               id_ff[i]  <= id_ff[i+1];
               pri_ff[i] <= pri_ff[i+1];
               tim_ff[i] <= tim_ff[i+1];
            end
         end
      end
      if (ctrl.finish) begin
         status_ff <= ctrl.fail;
         oid_ff    <= ctrl.pop ? 16'(id_ff[0]) : 16'd0;
         opri_ff   <= ctrl.pop ? pri_ff[0] : 16'd0;
         osize_ff  <= 5'(count_in);
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_job_id   = oid_ff;
   assign rsp_out_priority = opri_ff;
   assign rsp_queue_size   = osize_ff;

endmodule

// ===== design/apjq_ctrl.sv =====
// ---------------------------------------------------------------------------
// apjq_ctrl
// Sequencer for put scan, get and delete search.
// ---------------------------------------------------------------------------
module apjq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  apjq_pkg::stat_type stat,
   output apjq_pkg::ctrl_type ctrl
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DISP = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_CMP  = 5'b01000,
      ST_SRCH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = ST_DISP;
            end
         end
         ST_DISP: begin
            state_in    = ST_IDLE;
            ctrl.finish = 1'b1;
            case (stat.cmd)
               apjq_pkg::CMD_PUT: begin
                  if (stat.full) ctrl.fail = 1'b1;
                  else if (stat.scan_end) ctrl.do_insert = 1'b1;
                  else begin
                     ctrl.finish    = 1'b0;
                     ctrl.div_start = 1'b1;
                     state_in       = ST_DIV;
                  end
               end
               apjq_pkg::CMD_GET: begin
                  if (stat.empty) ctrl.fail = 1'b1;
                  else begin
                     ctrl.pop       = 1'b1;
                     ctrl.do_remove = 1'b1;
                  end
               end
               apjq_pkg::CMD_DEL: begin
                  ctrl.finish = 1'b0;
                  state_in    = ST_SRCH;
               end
               default: ctrl.fail = 1'b1;
            endcase
         end
         ST_DIV: begin
            if (stat.div_done) state_in = ST_CMP;
         end
         ST_CMP: begin
            if (stat.prio_gt) begin
               ctrl.do_insert = 1'b1;
               ctrl.finish    = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               ctrl.step = 1'b1;
               state_in  = ST_DISP;
            end
         end
         ST_SRCH: begin
            if (stat.scan_end) begin
               ctrl.fail   = 1'b1;
               ctrl.finish = 1'b1;
               state_in    = ST_IDLE;
            end else if (stat.id_hit) begin
               ctrl.do_remove = 1'b1;
               ctrl.finish    = 1'b1;
               state_in       = ST_IDLE;
            end else ctrl.step = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
